FILE: sv/fpfa_pkg.sv
// Shared constants for the fixed-partition fit allocator.
package fpfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  localparam int SIZE_W     = 16;
  localparam int OP_W       = 2;
  localparam int PIDX_W     = 4;
  localparam int PART_NUM_W = 5;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 1'd1;

  localparam logic [MODE_W-1:0]  FIT_MODE_RESET        = MODE_FIRST;
  localparam logic [COUNT_W-1:0] PARTITION_COUNT_RESET = 5'd16;

endpackage

FILE: sv/fpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator: sequencer, scan compare and tables.
//
// Input channel (in_valid / in_stall, op, part_index, amount): a transaction is
// taken when in_valid is high and in_stall low. in_stall is low only while the
// sequencer is idle.
//   load    : writes both size tables in the accepting cycle and stays idle.
//   restore : copies the original sizes into the free sizes, one entry a cycle
//             through the RAM read port; busy until all MAX_PARTITIONS are copied.
//   request : scans the first limit entries of the free-size RAM one entry a cycle
//             through one shared compare unit (limit = partition_count, capped at
//             the table size), then writes back the chosen entry, if one fits.
// Output channel (out_valid / out_stall, granted, part_number): one transaction
// per request, held in an output register. While the receiver stalls, the
// result holds and the block may take a load; a finished request waits in its
// write-back step until the previous result has been taken.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while idle.
// Reset (rst, synchronous): sequencer idle, no result pending, fit_mode first
// fit, partition_count 16. Table contents are undefined until loaded.
module fixed_partition_fit_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fpfa_pkg::OP_W-1:0]           op,
  input  logic [fpfa_pkg::PIDX_W-1:0]         part_index,
  input  logic [fpfa_pkg::SIZE_W-1:0]         amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                granted,
  output logic [fpfa_pkg::PART_NUM_W-1:0]     part_number,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_WRITE   = 4'b0100,
    S_RESTORE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [fpfa_pkg::MODE_W-1:0]  fit_mode;
  logic [fpfa_pkg::COUNT_W-1:0] partition_count;
  logic [fpfa_pkg::CNT_W-1:0]   limit;

  logic [fpfa_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         pend, pend_next;
  logic [fpfa_pkg::IDX_W-1:0]   pend_addr, pend_addr_next;
  logic                         found, found_next;
  logic [fpfa_pkg::IDX_W-1:0]   chosen, chosen_next;
  logic [fpfa_pkg::SIZE_W-1:0]  chosen_size, chosen_size_next;
  logic [fpfa_pkg::SIZE_W-1:0]  want, want_next;
  logic                         out_valid_next;

  logic                         in_fire;
  logic                         out_free;
  logic                         issue;
  logic                         fits;
  logic                         take;

  logic                         free_we, orig_we;
  logic [fpfa_pkg::IDX_W-1:0]   free_waddr, free_raddr, orig_raddr;
  logic [fpfa_pkg::SIZE_W-1:0]  free_wdata, free_rdata, orig_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (int'(partition_count) > fpfa_pkg::MAX_PARTITIONS) begin
      limit = fpfa_pkg::CNT_W'(fpfa_pkg::MAX_PARTITIONS);
    end else begin
      limit = fpfa_pkg::CNT_W'(partition_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= fpfa_pkg::FIT_MODE_RESET;
      partition_count <= fpfa_pkg::PARTITION_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpfa_pkg::REG_FIT_MODE:        fit_mode <= cfg_data[fpfa_pkg::MODE_W-1:0];
        fpfa_pkg::REG_PARTITION_COUNT: partition_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared compare unit
  assign fits = (free_rdata >= want);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      case (fit_mode)
        fpfa_pkg::MODE_BEST:  take = !found || (free_rdata <= chosen_size);
        fpfa_pkg::MODE_WORST: take = !found || (free_rdata >= chosen_size);
        default:              take = !found;
      endcase
    end
  end

  assign issue = (cnt < ((state == S_RESTORE) ?
                         fpfa_pkg::CNT_W'(fpfa_pkg::MAX_PARTITIONS) : limit));

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pend_next        = 1'b0;
    pend_addr_next   = cnt[fpfa_pkg::IDX_W-1:0];
    found_next       = found;
    chosen_next      = chosen;
    chosen_size_next = chosen_size;
    want_next        = want;
    out_valid_next   = out_valid && out_stall;

    free_we    = 1'b0;
    free_waddr = fpfa_pkg::IDX_W'(part_index);
    free_wdata = amount;
    orig_we    = 1'b0;
    free_raddr = cnt[fpfa_pkg::IDX_W-1:0];
    orig_raddr = cnt[fpfa_pkg::IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cnt_next   = '0;
          found_next = 1'b0;
          case (op)
            fpfa_pkg::OP_LOAD: begin
              if (int'(part_index) < fpfa_pkg::MAX_PARTITIONS) begin
                free_we = 1'b1;
                orig_we = 1'b1;
              end
            end
            fpfa_pkg::OP_REQUEST: begin
              want_next  = amount;
              state_next = S_SCAN;
            end
            fpfa_pkg::OP_RESTORE: state_next = S_RESTORE;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (pend && take) begin
          found_next       = 1'b1;
          chosen_next      = pend_addr;
          chosen_size_next = free_rdata;
        end
        if (issue) begin
          pend_next = 1'b1;
          cnt_next  = cnt + fpfa_pkg::CNT_W'(1);
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        free_waddr = chosen;
        free_wdata = chosen_size - want;
        if (out_free) begin
          free_we        = found;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RESTORE: begin
        free_waddr = pend_addr;
        free_wdata = orig_rdata;
        free_we    = pend;
        if (issue) begin
          pend_next = 1'b1;
          cnt_next  = cnt + fpfa_pkg::CNT_W'(1);
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      found     <= found_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr   <= pend_addr_next;
    chosen      <= chosen_next;
    chosen_size <= chosen_size_next;
    want        <= want_next;
    if (state == S_WRITE && out_free) begin
      granted     <= found;
      part_number <= found ? (fpfa_pkg::PART_NUM_W'(chosen) + fpfa_pkg::PART_NUM_W'(1))
                           : '0;
    end
  end

  fpfa_ram #(
    .WIDTH (fpfa_pkg::SIZE_W),
    .DEPTH (fpfa_pkg::MAX_PARTITIONS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  fpfa_ram #(
    .WIDTH (fpfa_pkg::SIZE_W),
    .DEPTH (fpfa_pkg::MAX_PARTITIONS)
  ) u_orig_ram (
    .clk   (clk),
    .we    (orig_we),
    .waddr (fpfa_pkg::IDX_W'(part_index)),
    .wdata (amount),
    .raddr (orig_raddr),
    .rdata (orig_rdata)
  );

endmodule

FILE: sv/fpfa_checker.sv
// Port-level assertions for the fixed-partition fit allocator, with bind.
module fpfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [fpfa_pkg::OP_W-1:0]       op,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            granted,
  input logic [fpfa_pkg::PART_NUM_W-1:0] part_number
);

  // a request or restore transaction keeps the input busy next cycle
  a_busy_after_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op == fpfa_pkg::OP_REQUEST || op == fpfa_pkg::OP_RESTORE))
    |=> in_stall)
    else $error("input not busy after request or restore");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (part_number == '0))
    else $error("refused result carries a partition number");

  a_granted_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |->
    (part_number != '0 && int'(part_number) <= fpfa_pkg::MAX_PARTITIONS))
    else $error("granted partition number out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
    (out_valid && $stable(granted) && $stable(part_number)))
    else $error("stalled result changed");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .op          (op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .granted     (granted),
  .part_number (part_number)
);

FILE: dv/fixed_partition_fit_allocator_tb.sv
// Self-checking testbench for the fixed-partition fit allocator.
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_tb;
  import fpfa_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1700;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic                  ok;
    logic [PART_NUM_W-1:0] num;
  } grant_t;

  class fit_scoreboard;
    logic [SIZE_W-1:0]  free_tbl[MAX_PARTITIONS];
    logic [SIZE_W-1:0]  orig_tbl[MAX_PARTITIONS];
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    grant_t             grants_due[$];
    int                 errors;

    function new();
      mode   = FIT_MODE_RESET;
      count  = PARTITION_COUNT_RESET;
      errors = 0;
      foreach (free_tbl[i]) begin
        free_tbl[i] = '0;
        orig_tbl[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FIT_MODE) mode = val[MODE_W-1:0];
      else if (idx == REG_PARTITION_COUNT) count = val[COUNT_W-1:0];
    endfunction

    // Works out the effect of one accepted transaction on the tables.
    function void note_item(logic [OP_W-1:0] kind, logic [PIDX_W-1:0] pidx,
                            logic [SIZE_W-1:0] amt);
      int     lim;
      int     pick;
      grant_t g;
      lim  = (count > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(count);
      pick = -1;
      case (kind)
        OP_LOAD: begin
          free_tbl[pidx] = amt;
          orig_tbl[pidx] = amt;
        end
        OP_RESTORE: begin
          foreach (free_tbl[i]) free_tbl[i] = orig_tbl[i];
        end
        OP_REQUEST: begin
          for (int i = 0; i < lim; i++) begin
            if (amt <= free_tbl[i]) begin
              if (mode == MODE_BEST) begin
                if (pick < 0 || free_tbl[i] <= free_tbl[pick]) pick = i;
              end else if (mode == MODE_WORST) begin
                if (pick < 0 || free_tbl[i] >= free_tbl[pick]) pick = i;
              end else if (pick < 0) begin
                pick = i;
              end
            end
          end
          if (pick < 0) begin
            g.ok  = 1'b0;
            g.num = '0;
          end else begin
            free_tbl[pick] = free_tbl[pick] - amt;
            g.ok  = 1'b1;
            g.num = PART_NUM_W'(pick + 1);
          end
          grants_due.push_back(g);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic ok, logic [PART_NUM_W-1:0] num);
      grant_t g;
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result granted=%0b part_number=%0d", ok, num));
      end else begin
        g = grants_due.pop_front();
        if (ok !== g.ok)
          report_mismatch($sformatf("granted %0b, expected %0b", ok, g.ok));
        if (num !== g.num)
          report_mismatch($sformatf("part_number %0d, expected %0d", num, g.num));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       op;
  logic [PIDX_W-1:0]     part_index;
  logic [SIZE_W-1:0]     amount;
  logic                  out_valid;
  logic                  out_stall;
  logic                  granted;
  logic [PART_NUM_W-1:0] part_number;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fit_scoreboard sb;
  bit            calm_in;
  bit            calm_out;
  int            stall_left;
  int            idle_cycles;

  fixed_partition_fit_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .part_index  (part_index),
    .amount      (amount),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted     (granted),
    .part_number (part_number),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Transaction monitor and watchdog.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_item(op, part_index, amount);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(granted, part_number);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fixed_partition_fit_allocator test failed");
      $finish;
    end
  end

  // Result-side back-pressure.
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (calm_out || r < 65) begin
      out_stall <= 1'b0;
    end else if (r < 93) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(8, 40);
      out_stall <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [OP_W-1:0] kind, logic [PIDX_W-1:0] pidx,
                           logic [SIZE_W-1:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= kind;
    part_index <= pidx;
    amount     <= amt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
    wait_idle();
    write_one(REG_FIT_MODE, CFG_DATA_W'(mode));
    write_one(REG_PARTITION_COUNT, CFG_DATA_W'(count));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return SIZE_W'(100 * $urandom_range(1, 3));
    if (r < 65) return SIZE_W'($urandom_range(0, 2000));
    if (r < 90) return SIZE_W'($urandom);
    return (r < 95) ? '0 : '1;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_want();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 50) return SIZE_W'($urandom_range(1, 300));
    if (r < 80) return SIZE_W'($urandom_range(0, 2000));
    if (r < 95) return SIZE_W'($urandom);
    return '1;
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return COUNT_W'(1);
    if (r < 35) return COUNT_W'(MAX_PARTITIONS);
    if (r < 50) return COUNT_W'($urandom_range(MAX_PARTITIONS + 1, 31));
    return COUNT_W'($urandom_range(1, MAX_PARTITIONS));
  endfunction

  initial begin
    logic [SIZE_W-1:0] seed_sizes[MAX_PARTITIONS];
    int                sent;
    int                phase_len;
    int                r;
    seed_sizes = '{16'd0, 16'hFFFF, 16'd100, 16'd300, 16'd100, 16'd200, 16'd300, 16'd50,
                   16'd1, 16'hFFFE, 16'd100, 16'd300, 16'd0, 16'd7, 16'd200, 16'h8000};
    sb          = new();
    sent        = 0;
    calm_in     = 1'b0;
    calm_out    = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_LOAD;
    part_index  = '0;
    amount      = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FIT_MODE;
    cfg_data    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every entry is loaded before anything reads the tables.
    for (int i = 0; i < MAX_PARTITIONS; i++) send_item(OP_LOAD, PIDX_W'(i), seed_sizes[i]);
    send_item(OP_REQUEST, '0, '0);
    send_item(OP_REQUEST, 4'hF, '1);
    send_item(OP_REQUEST, '0, '1);
    send_item(OP_UNUSED, 4'hF, '1);
    send_item(OP_RESTORE, 4'h5, 16'h1234);
    set_regs(MODE_BEST, COUNT_W'(MAX_PARTITIONS));
    send_item(OP_REQUEST, '0, 16'd100);
    send_item(OP_REQUEST, '0, '1);
    set_regs(MODE_WORST, COUNT_W'(MAX_PARTITIONS));
    send_item(OP_REQUEST, '0, 16'd1);
    send_item(OP_REQUEST, '0, 16'd200);
    set_regs(MODE_UNUSED, COUNT_W'(MAX_PARTITIONS));
    send_item(OP_REQUEST, '0, 16'd5);
    set_regs(MODE_FIRST, '0);
    send_item(OP_REQUEST, '0, '0);
    set_regs(MODE_WORST, '1);
    send_item(OP_REQUEST, '0, 16'h8000);
    set_regs(MODE_BEST, COUNT_W'(1));
    send_item(OP_REQUEST, '0, '0);
    send_item(OP_LOAD, 4'hF, '1);
    send_item(OP_RESTORE, '0, '0);

    while (sent < ITEM_TARGET) begin
      set_regs(MODE_W'($urandom_range(0, 3)), rand_count());
      calm_in   = ($urandom_range(0, 4) == 0);
      calm_out  = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 80);
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send_item(OP_LOAD, PIDX_W'($urandom), rand_size());
          sent++;
        end else if (r < 80) begin
          send_item(OP_REQUEST, PIDX_W'($urandom), rand_want());
          sent++;
        end else if (r < 93) begin
          send_item(OP_RESTORE, PIDX_W'($urandom), SIZE_W'($urandom));
          sent++;
        end else begin
          send_item(OP_UNUSED, PIDX_W'($urandom), SIZE_W'($urandom));
        end
      end
    end

    calm_out = 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.grants_due.size() == 0) begin
      $display("fixed_partition_fit_allocator test passed");
    end else begin
      $display("fixed_partition_fit_allocator test failed");
    end
    $finish;
  end

endmodule
